@@ hdl/vwdi_pkg.sv @@
// ----------------------------------------------------------------------------
// vwdi_pkg: shared types and constants for the vertex weld indexer
// Table geometry, item, queue-head, config and RAM request records, and config register codes.
// ----------------------------------------------------------------------------
package vwdi_pkg;

  // Unique-vertex table depth (2 .. 65536)
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W + 1;
  localparam int SUM_W       = SQ_W + 2;
  localparam int THR_W       = 50;
  localparam int VIDX_W      = 10;
  localparam int ENTRY_W     = 6 * COORD_W;
  localparam int QUEUE_DEPTH = 2;

  // Config port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REG_NORMALS   = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   start_mesh;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t norm_x;
    coord_t norm_y;
    coord_t norm_z;
  } item_t;

  // Front-to-back queue head
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             normals;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } scan_state_t;

  function automatic logic [SQ_W-1:0] sq_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    logic signed [2*DIFF_W-1:0] p;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  // Low VIDX_W bits of a table index, zero-extended when the index is narrower
  function automatic logic [VIDX_W-1:0] to_vidx(input logic [IDX_W-1:0] i);
    logic [IDX_W+VIDX_W-1:0] w;
    w = {{VIDX_W{1'b0}}, i};
    return w[VIDX_W-1:0];
  endfunction

endpackage

@@ hdl/vwdi_ram.sv @@
// ----------------------------------------------------------------------------
// vwdi_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vwdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/vwdi_front.sv @@
// ----------------------------------------------------------------------------
// vwdi_front: request intake
// Accepts vertex requests into a short queue ahead of the table scan.
// ----------------------------------------------------------------------------
module vwdi_front import vwdi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full       = (cnt_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Payload store, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

@@ hdl/vwdi_scan.sv @@
// ----------------------------------------------------------------------------
// vwdi_scan: table scan and append engine
// Walks the unique table one entry a cycle, reports the first match or
// appends the vertex, or flags the table full when it has no room.
// ----------------------------------------------------------------------------
module vwdi_scan import vwdi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  q_head_t            head,
  output logic               pop,
  input  cfg_t               cfg,
  output ram_req_t           ram_req,
  input  logic [ENTRY_W-1:0] ram_rdata,
  output logic               out_valid_r,
  output logic [VIDX_W-1:0]  out_vertex_index_r,
  output logic               out_is_new_r,
  output logic               out_table_full_r
);

  scan_state_t      state_r, state_nxt;
  item_t            item_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             v1_r, v2_r;
  logic [IDX_W-1:0] idx1_r, idx2_r;
  logic [SQ_W-1:0]  sq_r [6];
  coord_t           e_px, e_py, e_pz, e_nx, e_ny, e_nz;
  logic [SUM_W-1:0] pos_sum, norm_sum;
  logic             pos_ok, norm_ok;
  logic             hit, issue, finish, has_room;

  assign {e_nz, e_ny, e_nx, e_pz, e_py, e_px} = ram_rdata;

  // Sum and compare the registered squares
  assign pos_sum  = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  assign norm_sum = SUM_W'(sq_r[3]) + SUM_W'(sq_r[4]) + SUM_W'(sq_r[5]);
  assign pos_ok   = pos_sum < SUM_W'(cfg.threshold);
  assign norm_ok  = !cfg.normals || (norm_sum < SUM_W'(cfg.threshold));
  assign has_room = cnt_r < CNT_W'(TABLE_DEPTH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop    = 1'b0;
    hit    = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        pop = head.valid;
      end
      S_SCAN: begin
        hit    = v2_r && pos_ok && norm_ok;
        issue  = !hit && (ptr_r < cnt_r);
        finish = !hit && (ptr_r >= cnt_r) && !v1_r && !v2_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    if (pop) begin
      ptr_nxt = '0;
      if (head.item.start_mesh) begin
        cnt_nxt = '0;
      end
    end else if (issue) begin
      ptr_nxt = ptr_r + 1'b1;
    end
    if (finish && has_room) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign ram_req.we    = finish && has_room;
  assign ram_req.waddr = cnt_r[IDX_W-1:0];
  assign ram_req.wdata = {item_r.norm_z, item_r.norm_y, item_r.norm_x,
                          item_r.pos_z, item_r.pos_y, item_r.pos_x};
  assign ram_req.raddr = ptr_r[IDX_W-1:0];

  // Payload: held vertex, index tags, squares and result fields
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head.item;
    end
    idx1_r   <= ptr_r[IDX_W-1:0];
    idx2_r   <= idx1_r;
    sq_r[0]  <= sq_diff(e_px, item_r.pos_x);
    sq_r[1]  <= sq_diff(e_py, item_r.pos_y);
    sq_r[2]  <= sq_diff(e_pz, item_r.pos_z);
    sq_r[3]  <= sq_diff(e_nx, item_r.norm_x);
    sq_r[4]  <= sq_diff(e_ny, item_r.norm_y);
    sq_r[5]  <= sq_diff(e_nz, item_r.norm_z);
    out_vertex_index_r <= hit ? to_vidx(idx2_r)
                        : (has_room ? to_vidx(cnt_r[IDX_W-1:0]) : '0);
    out_is_new_r       <= !hit && has_room;
    out_table_full_r   <= !hit && !has_room;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r && !hit;
      out_valid_r <= hit || finish;
    end
  end

  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_new_r && out_table_full_r))
    else $error("result flagged both new and full");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("unique count beyond table depth");

  a_new_bumps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_new_r |-> cnt_r == $past(cnt_r) + 1'b1)
    else $error("append without count advance");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (hit || finish) |-> state_r == S_SCAN && !pop)
    else $error("scan result outside scan state");

endmodule

@@ hdl/vertex_weld_dedup_indexer.sv @@
// ----------------------------------------------------------------------------
// vertex_weld_dedup_indexer: mesh vertex welding indexer
// Maps each incoming vertex to the index of the first stored unique vertex
// within the squared-distance threshold, or appends it if the table has room.
// ----------------------------------------------------------------------------
// Each request holds the scan while it is taken from the queue, while the N
// unique vertices stored when it starts (0 after start_mesh) are read, and
// while the last read, its squares and the compare drain. An empty table
// needs no entry reads, and a match ends the scan early. The result appears
// in the cycle after the scan ends. The scan speed is set by the single
// read port of the vertex table: the scan reads one stored entry per cycle
// and stops at the first match. A two-deep request queue sits ahead of the
// scan, so start may be issued while an earlier vertex is still scanning;
// busy rises only when that queue is full. Every request yields exactly one
// result, shown for one cycle on out_valid; the receiver cannot stall it, so
// take it when it appears. Write the config registers only while no request
// is outstanding. The table needs no clearing pass after reset: entries are
// read only after being written.
// ----------------------------------------------------------------------------
module vertex_weld_dedup_indexer import vwdi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_start_mesh,
  input  logic signed [23:0]   in_pos_x,
  input  logic signed [23:0]   in_pos_y,
  input  logic signed [23:0]   in_pos_z,
  input  logic signed [23:0]   in_norm_x,
  input  logic signed [23:0]   in_norm_y,
  input  logic signed [23:0]   in_norm_z,
  // Result channel
  output logic                 out_valid,
  output logic [VIDX_W-1:0]    out_vertex_index,
  output logic                 out_is_new,
  output logic                 out_table_full,
  // Config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  item_t              req_item;
  q_head_t            head;
  logic               q_full;
  logic               pop;
  cfg_t               cfg;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [THR_W-1:0]   threshold_r;
  logic               normals_r;

  // Config registers: cfg_ready is held high, so every write is accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_W'(1);
      normals_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REG_THRESHOLD: threshold_r <= cfg_data;
        CFG_REG_NORMALS:   normals_r   <= cfg_data[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign cfg.threshold = threshold_r;
  assign cfg.normals   = normals_r;

  // Pack the request
  assign req_item.start_mesh = in_start_mesh;
  assign req_item.pos_x      = in_pos_x;
  assign req_item.pos_y      = in_pos_y;
  assign req_item.pos_z      = in_pos_z;
  assign req_item.norm_x     = in_norm_x;
  assign req_item.norm_y     = in_norm_y;
  assign req_item.norm_z     = in_norm_z;

  // Hold off new requests only while the queue is full
  assign busy = q_full;

  vwdi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_item (req_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  vwdi_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .cfg                (cfg),
    .ram_req            (ram_req),
    .ram_rdata          (ram_rdata),
    .out_valid_r        (out_valid),
    .out_vertex_index_r (out_vertex_index),
    .out_is_new_r       (out_is_new),
    .out_table_full_r   (out_table_full)
  );

  // Unique vertex table: position and normal of each entry in one word
  vwdi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
